// File: hw/rtl/owl_pkg.sv
// Shared types and constants for the ordered word list engine.
package owl_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  // position math is wide enough for the 8-bit request fields and for the count
  localparam int unsigned POS_W     = (CNT_W > 9) ? CNT_W : 9;
  localparam int unsigned LEAVES    = 2 ** IDX_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_READ      = 3'd1,
    OP_POP       = 3'd2,
    OP_WRITE     = 3'd3,
    OP_INSERT    = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DEL_RANGE = 3'd6,
    OP_DEL_VALUE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_MATCH
  } state_e;

  typedef enum logic [2:0] {
    CK_HOLD,
    CK_WRITE,
    CK_INSERT,
    CK_DELETE,
    CK_DELMATCH
  } cell_kind_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_kind_e kind;
    pos_t       pos;
    word_t      word;
  } cell_cmd_t;

endpackage

// File: hw/rtl/ordered_word_list_engine_unit.sv
// Top level of the ordered word list engine: control sequencer and the cell chain.
// An accepted transaction executes in the next cycle, then valid_o is high for one cycle
// with the result; a range deletion of n entries drops one in execute and shifts one place
// per cycle for the rest, a value deletion compares in execute and shifts in the match state.
// A new transaction is not taken while one is in progress; start is taken again in the result cycle.
// Results are never stalled. Reset clears the count and the sequencer; words stay undefined.
module ordered_word_list_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  index_i,
  input  logic [7:0]  end_index_i,
  input  logic [31:0] value_i,
  output logic        valid_o,
  output logic [31:0] data_o,
  output logic [8:0]  count_o,
  output logic [1:0]  status_o
);
  import owl_pkg::*;

  state_e state_q, state_d;

  // latched request (payload, no reset)
  op_e   req_op_q;
  pos_t  req_idx_q;
  pos_t  req_end_q;
  word_t req_word_q;

  cnt_t  used_q, used_d;
  pos_t  cnt_q, cnt_d;

  logic  res_valid_q, res_valid_d;
  word_t res_data_q, res_data_d;
  status_e res_status_q, res_status_d;

  logic [DEPTH-1:0] match_q;
  logic [DEPTH-1:0] match_raw;
  logic [DEPTH-1:0] valid_v;
  logic [DEPTH-1:0] pfx;
  logic             found;

  cell_cmd_t cmd;
  word_t     cell_word [DEPTH];

  logic  accept;
  logic  fin, go_shift, go_match;
  pos_t  u, rd_pos, end_clamp;
  word_t rd_word;
  word_t rd_tree [IDX_W+1][LEAVES];

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign u      = POS_W'(used_q);

  // ---------------------------------------------------------------------------
  // Cell chain: each cell sees its two neighbors; the ends see zero.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t lower_w, upper_w;
    if (g == 0) begin : g_lo
      assign lower_w = '0;
    end else begin : g_lo
      assign lower_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign upper_w = '0;
    end else begin : g_hi
      assign upper_w = cell_word[g+1];
    end

    owl_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .pfx_i   (pfx[g]),
      .word_o  (cell_word[g]),
      .match_o (match_raw[g])
    );

    assign valid_v[g] = (POS_W'(g) < u);
  end

  // first match over the registered flags
  owl_find u_find (
    .match_i (match_q),
    .pfx_o   (pfx),
    .any_o   (found)
  );

  // ---------------------------------------------------------------------------
  // Read port: pick one cell by position through a balanced OR tree.
  // ---------------------------------------------------------------------------
  assign rd_pos = ((req_op_q == OP_POP) || (req_idx_q >= u)) ? (u - 1'b1) : req_idx_q;

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if ((i < DEPTH) && (POS_W'(i) == rd_pos)) rd_tree[0][i] = cell_word[i % DEPTH];
      else                                     rd_tree[0][i] = '0;
    end
    for (int s = 0; s < IDX_W; s++) begin
      for (int i = 0; i < LEAVES; i++) begin
        if (i < (LEAVES >> (s + 1))) rd_tree[s+1][i] = rd_tree[s][2*i] | rd_tree[s][2*i+1];
        else                         rd_tree[s+1][i] = '0;
      end
    end
  end

  assign rd_word   = rd_tree[IDX_W][0];
  assign end_clamp = (req_end_q >= u) ? (u - 1'b1) : req_end_q;

  // ---------------------------------------------------------------------------
  // Decode: chain command, count update and result for the current cycle.
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd          = '{kind: CK_HOLD, pos: req_idx_q, word: req_word_q};
    used_d       = used_q;
    cnt_d        = cnt_q;
    fin          = 1'b0;
    go_shift     = 1'b0;
    go_match     = 1'b0;
    res_data_d   = '0;
    res_status_d = ST_OK;

    case (state_q)
      S_EXEC: begin
        fin = 1'b1;
        case (req_op_q)
          OP_READ: begin
            if (u == '0) res_status_d = ST_MISS;
            else         res_data_d   = rd_word;
          end
          OP_POP: begin
            if (u == '0) begin
              res_status_d = ST_MISS;
            end else begin
              res_data_d = rd_word;
              used_d     = used_q - 1'b1;
            end
          end
          OP_INSERT: begin
            if (u == POS_W'(DEPTH)) begin
              res_status_d = ST_FULL;
            end else if (req_idx_q >= u) begin
              cmd.kind = CK_WRITE;
              cmd.pos  = u;
              used_d   = used_q + 1'b1;
            end else begin
              cmd.kind = CK_INSERT;
              used_d   = used_q + 1'b1;
            end
          end
          OP_DEL_AT: begin
            if (req_idx_q < u) begin
              cmd.kind = CK_DELETE;
              used_d   = used_q - 1'b1;
            end else begin
              res_status_d = ST_MISS;
            end
          end
          OP_DEL_RANGE: begin
            if ((req_idx_q >= u) || (end_clamp < req_idx_q)) begin
              res_status_d = ST_MISS;
            end else begin
              // drop one entry now, the rest one per cycle
              cmd.kind = CK_DELETE;
              used_d   = used_q - 1'b1;
              cnt_d    = end_clamp - req_idx_q;
              if (end_clamp != req_idx_q) begin
                fin      = 1'b0;
                go_shift = 1'b1;
              end
            end
          end
          OP_DEL_VALUE: begin
            // compare this cycle, shift on the next
            fin      = 1'b0;
            go_match = 1'b1;
          end
          default: begin
            // append, and write: in place below the count, else appended at the end
            if ((req_op_q == OP_WRITE) && (req_idx_q < u)) begin
              cmd.kind = CK_WRITE;
            end else if (u == POS_W'(DEPTH)) begin
              res_status_d = ST_FULL;
            end else begin
              cmd.kind = CK_WRITE;
              cmd.pos  = u;
              used_d   = used_q + 1'b1;
            end
          end
        endcase
      end
      S_SHIFT: begin
        cmd.kind = CK_DELETE;
        used_d   = used_q - 1'b1;
        cnt_d    = cnt_q - 1'b1;
        fin      = (cnt_q == POS_W'(1));
      end
      S_MATCH: begin
        fin = 1'b1;
        if (found) begin
          cmd.kind = CK_DELMATCH;
          used_d   = used_q - 1'b1;
        end else begin
          res_status_d = ST_MISS;
        end
      end
      default: begin
        cmd.kind = CK_HOLD;
      end
    endcase
    res_valid_d = fin;
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (go_shift)      state_d = S_SHIFT;
        else if (go_match) state_d = S_MATCH;
        else               state_d = S_IDLE;
      end
      S_SHIFT: begin
        if (fin) state_d = S_IDLE;
      end
      S_MATCH: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
    end
  end

  // hold the request and working payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_op_q   <= op_e'(req_type_i);
      req_idx_q  <= POS_W'(index_i);
      req_end_q  <= POS_W'(end_index_i);
      req_word_q <= WORD_BITS'(value_i);
    end
    cnt_q        <= cnt_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    if (state_q == S_EXEC) match_q <= match_raw & valid_v;
  end

  assign valid_o  = res_valid_q;
  assign data_o   = 32'(res_data_q);
  assign count_o  = 9'(used_q);
  assign status_o = res_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    POS_W'(used_q) <= POS_W'(DEPTH))
    else $error("entry count exceeds capacity");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) != S_IDLE))
    else $error("result strobe without a transaction in progress");

  a_accept_enters_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_EXEC))
    else $error("accepted transaction did not enter execute");

  a_full_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_FULL)) |-> (POS_W'(used_q) == POS_W'(DEPTH)))
    else $error("full status below capacity");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != ST_OK)) |-> (data_o == '0))
    else $error("failed transaction returned data");

endmodule

// File: hw/rtl/owl_cell.sv
// One storage cell of the list chain: holds a word and trades it with its neighbors.
module owl_cell (
  input  logic                    clk_i,
  input  logic [owl_pkg::IDX_W-1:0] pos_i,
  input  owl_pkg::cell_cmd_t      cmd_i,
  input  owl_pkg::word_t          lower_i,
  input  owl_pkg::word_t          upper_i,
  input  logic                    pfx_i,
  output owl_pkg::word_t          word_o,
  output logic                    match_o
);
  import owl_pkg::*;

  word_t word_q;
  word_t word_d;
  pos_t  my_pos;

  assign my_pos = POS_W'(pos_i);

  always_comb begin
    word_d = word_q;
    case (cmd_i.kind)
      CK_WRITE: begin
        if (my_pos == cmd_i.pos) word_d = cmd_i.word;
      end
      CK_INSERT: begin
        // take the lower neighbor above the slot, load the new word at it
        if (my_pos == cmd_i.pos) word_d = cmd_i.word;
        else if (my_pos > cmd_i.pos) word_d = lower_i;
      end
      CK_DELETE: begin
        if (my_pos >= cmd_i.pos) word_d = upper_i;
      end
      CK_DELMATCH: begin
        if (pfx_i) word_d = upper_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign match_o = (word_q == cmd_i.word);

endmodule

// File: hw/rtl/owl_find.sv
// Prefix OR over the per-cell match flags: marks every cell at or above the first hit.
module owl_find (
  input  logic [owl_pkg::DEPTH-1:0] match_i,
  output logic [owl_pkg::DEPTH-1:0] pfx_o,
  output logic                      any_o
);
  import owl_pkg::*;

  logic [DEPTH-1:0] lvl [IDX_W+1];

  // log-step prefix: each level doubles the reach
  always_comb begin
    lvl[0] = match_i;
    for (int s = 0; s < IDX_W; s++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << s)) lvl[s+1][i] = lvl[s][i] | lvl[s][i - (1 << s)];
        else               lvl[s+1][i] = lvl[s][i];
      end
    end
  end

  assign pfx_o = lvl[IDX_W];
  assign any_o = lvl[IDX_W][DEPTH-1];

endmodule
